// ===== hw/rtl/aubp_pkg.sv =====
// Package for the audio band-pass IIR block: widths, register indexes,
// sequencer states and the 32-bit saturation helper. No dependencies.
package aubp_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int STATE_W   = 32;
    localparam int FRAC_BITS = 12;
    localparam int CFG_ADDR_W = 8;
    // Multiplier operand: 32-bit state plus scaled 17-bit sample delta
    localparam int OP_W      = 34;
    localparam int PROD_W    = OP_W + COEF_W + 1;
    localparam int SHIFT_W   = PROD_W - COEF_W;
    localparam int ACC_W     = SHIFT_W + 1;

    // Coefficient reset values (80 Hz high-pass, 3 kHz low-pass at 16 kHz)
    localparam logic [COEF_W-1:0] HP_COEF_RST = 16'd63539;
    localparam logic [COEF_W-1:0] LP_COEF_RST = 16'd35447;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HP_COEF = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LP_COEF = 8'd1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HP_MUL,
        ST_HP_ACC,
        ST_LP1_DIFF,
        ST_LP1_MUL,
        ST_LP1_ACC,
        ST_LP2_DIFF,
        ST_LP2_MUL,
        ST_LP2_ACC,
        ST_EMIT
    } seq_state_t;

    // Clamp a wide signed sum into the signed 32-bit range
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-STATE_W:0] top;
        begin
            top = v[ACC_W-1:STATE_W-1];
            if (top == '0 || top == '1) begin
                sat_state = v[STATE_W-1:0];
            end else if (v[ACC_W-1]) begin
                sat_state = {1'b1, {(STATE_W-1){1'b0}}};
            end else begin
                sat_state = {1'b0, {(STATE_W-1){1'b1}}};
            end
        end
    endfunction

endpackage

// ===== hw/rtl/audio_bandpass_iir_unit.sv =====
// An input item is accepted only in the idle state, so a new item is not taken
// until the previous one has left the sequencer; the single shared 17x34 multiplier
// is used once per filter stage, three times per item, under a sequencer.
// The result register frees the input side while a result waits.
// Reset (aresetn low, synchronous): filter state cleared, coefficients set
// to their 80 Hz / 3 kHz defaults, no result pending.
module audio_bandpass_iir_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aubp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [aubp_pkg::COEF_W-1:0]      cfg_wdata,
    // Input samples
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [aubp_pkg::SAMPLE_W-1:0]    s_tdata,   // [15:0] sample_in
    input  logic                             s_tlast,   // block_end_in
    // Filtered samples
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [aubp_pkg::SAMPLE_W-1:0]    m_tdata,   // [15:0] sample_out
    output logic                             m_tlast,   // block_end_out
    output logic                             m_tuser    // [0] clipped
);
    import aubp_pkg::*;

    seq_state_t state_reg, state_next;

    logic [COEF_W-1:0]          hp_coef_reg, lp_coef_reg;
    logic signed [SAMPLE_W-1:0] prev_in_reg, prev_in_next;
    logic signed [STATE_W-1:0]  hp_reg, hp_next;
    logic signed [STATE_W-1:0]  lp1_reg, lp1_next;
    logic signed [STATE_W-1:0]  lp2_reg, lp2_next;
    logic signed [OP_W-1:0]     op_reg, op_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       last_reg, last_next;

    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_clip_reg, out_clip_next;

    logic                       in_fire;
    logic                       out_free;
    logic signed [COEF_W:0]     coef_op;
    logic signed [SHIFT_W-1:0]  prod_sh;
    logic signed [STATE_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [STATE_W-1:0]  acc_sat;
    logic signed [SAMPLE_W:0]   in_delta;
    logic signed [STATE_W:0]    lp_diff;
    logic signed [STATE_W:0]    trunc_adj;
    logic signed [STATE_W-FRAC_BITS:0] trunc_q;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_clip_reg;

    // Shared multiplier: coefficient times the registered operand
    assign coef_op   = $signed({1'b0, (state_reg == ST_HP_MUL) ? hp_coef_reg : lp_coef_reg});
    assign prod_next = coef_op * op_reg;

    // Floor shift of the product, add the stage base, clamp to 32 bits
    assign prod_sh = prod_reg[PROD_W-1:COEF_W];
    always_comb begin
        unique case (state_reg)
            ST_LP1_ACC: acc_base = lp1_reg;
            ST_LP2_ACC: acc_base = lp2_reg;
            default:    acc_base = '0;
        endcase
    end
    assign acc_sum = {{(ACC_W-STATE_W){acc_base[STATE_W-1]}}, acc_base}
                   + {prod_sh[SHIFT_W-1], prod_sh};
    assign acc_sat = sat_state(acc_sum);

    // Operand builders: high-pass input delta and low-pass difference
    assign in_delta = {s_tdata[SAMPLE_W-1], s_tdata} - {prev_in_reg[SAMPLE_W-1], prev_in_reg};
    assign lp_diff  = (state_reg == ST_LP1_DIFF)
                    ? ({hp_reg[STATE_W-1], hp_reg} - {lp1_reg[STATE_W-1], lp1_reg})
                    : ({lp1_reg[STATE_W-1], lp1_reg} - {lp2_reg[STATE_W-1], lp2_reg});

    // Truncate toward zero: bias negatives before the arithmetic shift
    assign trunc_adj = {lp2_reg[STATE_W-1], lp2_reg}
                     + (lp2_reg[STATE_W-1] ? (STATE_W+1)'((1 << FRAC_BITS) - 1)
                                           : (STATE_W+1)'(0));
    assign trunc_q   = trunc_adj[STATE_W:FRAC_BITS];

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire) state_next = ST_HP_MUL;
            ST_HP_MUL:   state_next = ST_HP_ACC;
            ST_HP_ACC:   state_next = ST_LP1_DIFF;
            ST_LP1_DIFF: state_next = ST_LP1_MUL;
            ST_LP1_MUL:  state_next = ST_LP1_ACC;
            ST_LP1_ACC:  state_next = ST_LP2_DIFF;
            ST_LP2_DIFF: state_next = ST_LP2_MUL;
            ST_LP2_MUL:  state_next = ST_LP2_ACC;
            ST_LP2_ACC:  state_next = ST_EMIT;
            ST_EMIT:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates per state
    always_comb begin
        prev_in_next   = prev_in_reg;
        hp_next        = hp_reg;
        lp1_next       = lp1_reg;
        lp2_next       = lp2_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_clip_next  = out_clip_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    op_next = {{(OP_W-STATE_W){hp_reg[STATE_W-1]}}, hp_reg}
                            + ({{(OP_W-SAMPLE_W-1){in_delta[SAMPLE_W]}}, in_delta}
                               <<< FRAC_BITS);
                    prev_in_next = s_tdata;
                    last_next    = s_tlast;
                end
            end
            ST_HP_ACC:  hp_next  = acc_sat;
            ST_LP1_ACC: lp1_next = acc_sat;
            ST_LP2_ACC: lp2_next = acc_sat;
            ST_LP1_DIFF, ST_LP2_DIFF: begin
                op_next = {lp_diff[STATE_W], lp_diff};
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = last_reg;
                    if (trunc_q > $signed((STATE_W-FRAC_BITS+1)'(32767))) begin
                        out_data_next = 16'h7fff;
                        out_clip_next = 1'b1;
                    end else if (trunc_q < -$signed((STATE_W-FRAC_BITS+1)'(32768))) begin
                        out_data_next = 16'h8000;
                        out_clip_next = 1'b1;
                    end else begin
                        out_data_next = trunc_q[SAMPLE_W-1:0];
                        out_clip_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hp_coef_reg   <= HP_COEF_RST;
            lp_coef_reg   <= LP_COEF_RST;
            prev_in_reg   <= '0;
            hp_reg        <= '0;
            lp1_reg       <= '0;
            lp2_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_in_reg   <= prev_in_next;
            hp_reg        <= hp_next;
            lp1_reg       <= lp1_next;
            lp2_reg       <= lp2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_addr == REG_HP_COEF) begin
                hp_coef_reg <= cfg_wdata;
            end
            if (cfg_valid && cfg_addr == REG_LP_COEF) begin
                lp_coef_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        prod_reg     <= prod_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_clip_reg <= out_clip_next;
    end

endmodule
